// ----- design/swsr_pkg.sv -----
package swsr_pkg;

  // Input beat kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_START_LOW_TICKS    = 2'd0;
  localparam logic [1:0] REG_SAMPLE_DELAY_TICKS = 2'd1;
  localparam logic [1:0] REG_BYTES_PER_READ     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] START_LOW_TICKS_RST    = 16'd18000;
  localparam logic [7:0]  SAMPLE_DELAY_TICKS_RST = 8'd30;
  localparam logic [2:0]  BYTES_PER_READ_RST     = 3'd5;

  localparam logic [2:0] BIT_INDEX_LAST = 3'd7;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_START     = 8'b0000_0010,
    PH_RESP_WAIT = 8'b0000_0100,
    PH_RESP_LOW  = 8'b0000_1000,
    PH_RESP_HIGH = 8'b0001_0000,
    PH_BIT_RISE  = 8'b0010_0000,
    PH_BIT_DELAY = 8'b0100_0000,
    PH_BIT_FALL  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  sample_delay_ticks;
    logic [2:0]  bytes_per_read;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       busy_res;
  } result_t;

endpackage

// ----- design/swsr_core.sv -----
module swsr_core import swsr_pkg::*; #(
  parameter int CounterWidth = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  logic    kind_i,
  input  logic    line_level_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam int LimWidth = (CounterWidth > 16) ? CounterWidth : 16;
  localparam logic [CounterWidth-1:0] CntMax = '1;

  phase_e                  phase_q, phase_d;
  logic [CounterWidth-1:0] tick_q, tick_d;
  logic [2:0]              bit_q, bit_d;
  logic [2:0]              byte_q, byte_d;
  logic [7:0]              shift_q, shift_d;

  logic [LimWidth-1:0]     lim_raw, lim_nz;
  logic [CounterWidth-1:0] lim, tick_inc;
  logic                    reached;
  logic [2:0]              nbytes;
  logic                    valid, last;

  // Limit of the running count, zero taken as one and clipped to the counter
  always_comb begin
    if (phase_q == PH_START) begin
      lim_raw = LimWidth'(cfg_i.start_low_ticks);
    end else begin
      lim_raw = LimWidth'(cfg_i.sample_delay_ticks);
    end
    lim_nz = (lim_raw == '0) ? LimWidth'(1) : lim_raw;
    lim    = (lim_nz > LimWidth'(CntMax)) ? CntMax : CounterWidth'(lim_nz);
  end

  assign tick_inc = (tick_q == CntMax) ? tick_q : tick_q + CounterWidth'(1);
  assign reached  = tick_inc >= lim;
  assign nbytes   = (cfg_i.bytes_per_read == '0) ? 3'd1 : cfg_i.bytes_per_read;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    valid   = 1'b0;
    last    = 1'b0;
    if (kind_i == KIND_START) begin
      if (phase_q == PH_IDLE) begin
        phase_d = PH_START;
        tick_d  = '0;
        bit_d   = '0;
        byte_d  = '0;
        shift_d = '0;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_START: begin
          tick_d = tick_inc;
          if (reached) begin
            phase_d = PH_RESP_WAIT;
            tick_d  = '0;
          end
        end
        PH_RESP_WAIT: if (!line_level_i) phase_d = PH_RESP_LOW;
        PH_RESP_LOW:  if (line_level_i)  phase_d = PH_RESP_HIGH;
        PH_RESP_HIGH: if (!line_level_i) phase_d = PH_BIT_RISE;
        PH_BIT_RISE: begin
          if (line_level_i) begin
            phase_d = PH_BIT_DELAY;
            tick_d  = '0;
          end
        end
        PH_BIT_DELAY: begin
          tick_d = tick_inc;
          if (reached) begin
            tick_d  = '0;
            shift_d = {shift_q[6:0], line_level_i};
            phase_d = PH_BIT_FALL;
            if (bit_q == BIT_INDEX_LAST) begin
              bit_d = '0;
              valid = 1'b1;
              if ({1'b0, byte_q} + 4'd1 >= {1'b0, nbytes}) begin
                last    = 1'b1;
                byte_d  = '0;
                phase_d = PH_IDLE;
              end else begin
                byte_d = byte_q + 3'd1;
              end
            end else begin
              bit_d = bit_q + 3'd1;
            end
          end
        end
        PH_BIT_FALL: if (!line_level_i) phase_d = PH_BIT_RISE;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  assign result_o.drive_low  = (phase_d == PH_START);
  assign result_o.byte_valid = valid;
  assign result_o.data_byte  = valid ? shift_d : 8'd0;
  assign result_o.last_byte  = last;
  assign result_o.busy_res   = (phase_d != PH_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
    end
  end

  a_byte_from_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && result_o.byte_valid |-> phase_q == PH_BIT_DELAY && bit_q == BIT_INDEX_LAST)
    else $error("byte given outside the last bit sample");

  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && result_o.last_byte |=> phase_q == PH_IDLE)
    else $error("last byte did not end the read");

  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q != PH_START && phase_d == PH_START |-> phase_q == PH_IDLE)
    else $error("start pulse entered while busy");

endmodule

// ----- design/swsr_out_buf.sv -----
module swsr_out_buf import swsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_ready_i,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer overflow");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |=> count_q == $past(count_q) + 2'd1)
    else $error("push lost");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q ^ rd_ptr_q) == count_q[0])
    else $error("pointers disagree with fill count");

endmodule

// ----- design/single_wire_sensor_reader_top.sv -----
// Host side of a single-wire humidity sensor read, stepped by time ticks.
//
// Input channel (in_valid_i / in_ready_o): each beat is either a start
// request (kind_i = 0) or one time tick (kind_i = 1) carrying the sampled
// level of the data line in line_level_i.
// Output channel (out_valid_o / out_ready_i): exactly one result beat per
// input beat, in order: the open-drain drive, a byte strobe with the byte
// and its last marker, and the busy flag, all as they stand after the beat.
// Configuration: write start_low_ticks, sample_delay_ticks and
// bytes_per_read through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
//
// The phase machine and tick counter update on the accepting beat, and
// its result is written into the result buffer and presented from there.
// The block takes one beat per cycle while the two-entry result buffer
// has room; the buffer keeps in_ready_o high while one result waits.
// When the receiver stalls, the buffer fills and in_ready_o drops after
// two pending results; nothing is lost.
// Reset clears the phase to idle, all counters and the buffer, and loads
// the default register values (18000, 30, 5).
module single_wire_sensor_reader_top import swsr_pkg::*; #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        line_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        drive_low_o,
  output logic        byte_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        last_byte_o,
  output logic        busy_res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg_q;
  result_t step_res, out_res;
  logic    accept;

  // Register writes; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks    <= START_LOW_TICKS_RST;
      cfg_q.sample_delay_ticks <= SAMPLE_DELAY_TICKS_RST;
      cfg_q.bytes_per_read     <= BYTES_PER_READ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_LOW_TICKS:    cfg_q.start_low_ticks    <= cfg_data_i;
        REG_SAMPLE_DELAY_TICKS: cfg_q.sample_delay_ticks <= cfg_data_i[7:0];
        REG_BYTES_PER_READ:     cfg_q.bytes_per_read     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Take a beat whenever the result buffer has room
  assign accept = in_valid_i && in_ready_o;

  swsr_core #(
    .CounterWidth(COUNTER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .line_level_i(line_level_i),
    .cfg_i       (cfg_q),
    .result_o    (step_res)
  );

  // Hold results here so a stalled receiver does not stop the phase machine
  swsr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .data_i     (step_res),
    .ready_o    (in_ready_o),
    .valid_o    (out_valid_o),
    .pop_ready_i(out_ready_i),
    .data_o     (out_res)
  );

  assign drive_low_o  = out_res.drive_low;
  assign byte_valid_o = out_res.byte_valid;
  assign data_byte_o  = out_res.data_byte;
  assign last_byte_o  = out_res.last_byte;
  assign busy_res_o   = out_res.busy_res;

endmodule
